@@ design/cba_pkg.sv @@
// ----------------------------------------------------------------------------
// cba_pkg: shared types and codes of the contiguous block allocator
// Request and status codes, field widths and the map control word.
// ----------------------------------------------------------------------------
package cba_pkg;

  // Field widths of the request and response words
  localparam int FUNC_W = 2;
  localparam int BLK_W  = 7;
  localparam int STAT_W = 2;

  // Default number of blocks held in the map
  localparam int NUM_BLOCKS_DEF = 128;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLAIM   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BUSY = 2'd1;
  localparam logic [STAT_W-1:0] ST_PAST = 2'd2;

  // Write control for the block map
  typedef struct packed {
    logic wr_en;
    logic wr_bit;
  } map_ctl_t;

endpackage

@@ design/cba_if.sv @@
// ----------------------------------------------------------------------------
// cba_req_if / cba_rsp_if: request and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cba_req_if;
  import cba_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BLK_W-1:0]  range_base;
  logic [BLK_W-1:0]  count;

  modport source (output valid, func, range_base, count, input ready);
  modport sink   (input valid, func, range_base, count, output ready);
endinterface

interface cba_rsp_if;
  import cba_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BLK_W-1:0]  granted_start;

  modport source (output valid, status, granted_start, input ready);
  modport sink   (input valid, status, granted_start, output ready);
endinterface

@@ design/contiguous_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// contiguous_block_allocator_top: first-fit contiguous block allocator
// Keeps a used/free bit per block; allocates first-fit runs, releases and
// claims ranges. One address counter and compare walk the map.
// ----------------------------------------------------------------------------
//  channel  modport  payload                          word moves on
//  req      sink     func, range_base, count          req.valid & req.ready
//  rsp      source   status, granted_start            rsp.valid & rsp.ready
//
//  One request at a time. Allocate scans the map one block a cycle from
//  block 1, then writes one block a cycle for the run found; claim scans
//  then writes count blocks; release writes count blocks, clipped at the
//  map end. The single map port sets these rates. After reset a clearing
//  pass over every block runs before req.ready.
//  A response held by rsp.ready stalls only the end of the next request.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_top
  import cba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cba_req_if.sink   req,
  cba_rsp_if.source rsp
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int EW = (AW + 1 > 8) ? AW + 1 : 8;
  localparam logic [AW-1:0] LAST_BLK = AW'(NUM_BLOCKS - 1);
  localparam logic [EW-1:0] NUM_E    = EW'(NUM_BLOCKS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     last;
  logic [AW-1:0]     scan_first;
  logic [AW-1:0]     chk_addr;
  logic              chk_valid;
  logic              chk_last;
  logic              issue_on;
  logic [BLK_W-1:0]  run;
  logic [BLK_W-1:0]  cnt;
  logic [BLK_W-1:0]  first_blk;
  logic              is_alloc;
  logic              wr_val;
  logic [STAT_W-1:0] res_status;
  logic [BLK_W-1:0]  res_start;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [BLK_W-1:0]  out_start;

  map_ctl_t          map_ctl;
  logic              map_rd;

  logic [EW-1:0]     first_e;
  logic [EW-1:0]     end_e;
  logic              past;
  logic [EW-1:0]     end_c;
  logic [EW-1:0]     alloc_first_e;

  // Range arithmetic on the incoming word
  always_comb begin
    first_e       = EW'(req.range_base);
    end_e         = first_e + EW'(req.count);
    past          = end_e > NUM_E;
    end_c         = past ? NUM_E : end_e;
    alloc_first_e = EW'(chk_addr) + EW'(1) - EW'(cnt);
  end

  // Map write control: clearing pass, then range writes sparing block 0
  always_comb begin
    map_ctl.wr_en  = (state == S_CLEAR) || ((state == S_WRITE) && (addr != '0));
    map_ctl.wr_bit = (state == S_CLEAR) ? (addr == '0) : wr_val;
  end

  cba_map #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_map (
    .clk    (clk),
    .ctl    (map_ctl),
    .addr   (addr),
    .rd_bit (map_rd)
  );

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.granted_start = out_start;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      out_valid <= 1'b0;
      issue_on  <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      // Drop the response once taken, unless a new one replaces it
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          if (addr == LAST_BLK) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            cnt       <= req.count;
            first_blk <= req.range_base;
            run       <= '0;
            chk_valid <= 1'b0;
            priority if (req.func == FUNC_ALLOC) begin
              if (req.count == '0) begin
                res_status <= ST_OK;
                res_start  <= '0;
                state      <= S_DONE;
              end else begin
                is_alloc <= 1'b1;
                addr     <= AW'(1);
                last     <= LAST_BLK;
                issue_on <= 1'b1;
                state    <= S_SCAN;
              end
            end else if (req.func == FUNC_RELEASE) begin
              res_status <= past ? ST_PAST : ST_OK;
              res_start  <= '0;
              if (first_e >= end_c) begin
                state <= S_DONE;
              end else begin
                addr   <= first_e[AW-1:0];
                last   <= AW'(end_c - EW'(1));
                wr_val <= 1'b0;
                state  <= S_WRITE;
              end
            end else if (req.func == FUNC_CLAIM) begin
              if (req.count == '0) begin
                res_status <= ST_OK;
                res_start  <= req.range_base;
                state      <= S_DONE;
              end else if (past) begin
                res_status <= ST_PAST;
                res_start  <= '0;
                state      <= S_DONE;
              end else begin
                is_alloc   <= 1'b0;
                addr       <= first_e[AW-1:0];
                scan_first <= first_e[AW-1:0];
                last       <= AW'(end_e - EW'(1));
                issue_on   <= 1'b1;
                state      <= S_SCAN;
              end
            end else begin
              res_status <= ST_BUSY;
              res_start  <= '0;
              state      <= S_DONE;
            end
          end
        end

        S_SCAN: begin
          // Issue the next map read
          chk_valid <= issue_on;
          chk_last  <= issue_on && (addr == last);
          chk_addr  <= addr;
          if (issue_on && (addr == last)) begin
            issue_on <= 1'b0;
          end
          // Judge the block read in the previous cycle; advance the address unless the scan ends
          if (chk_valid && map_rd) begin
            run <= '0;
            if (!is_alloc || chk_last) begin
              res_status <= ST_BUSY;
              res_start  <= '0;
              state      <= S_DONE;
            end else if (issue_on && (addr != last)) begin
              addr <= addr + 1'b1;
            end
          end else if (chk_valid && is_alloc && (run + 1'b1 == cnt)) begin
            addr       <= alloc_first_e[AW-1:0];
            last       <= chk_addr;
            wr_val     <= 1'b1;
            res_status <= ST_OK;
            res_start  <= alloc_first_e[BLK_W-1:0];
            state      <= S_WRITE;
          end else if (chk_valid && chk_last) begin
            if (is_alloc) begin
              res_status <= ST_BUSY;
              res_start  <= '0;
              state      <= S_DONE;
            end else begin
              addr       <= scan_first;
              wr_val     <= 1'b1;
              res_status <= ST_OK;
              res_start  <= first_blk;
              state      <= S_WRITE;
            end
          end else begin
            if (chk_valid) begin
              run <= run + 1'b1;
            end
            if (issue_on && (addr != last)) begin
              addr <= addr + 1'b1;
            end
          end
        end

        S_WRITE: begin
          if (addr == last) begin
            state <= S_DONE;
          end else begin
            addr <= addr + 1'b1;
          end
        end

        S_DONE: begin
          // Hold until the response slot is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_start  <= res_start;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/cba_map.sv @@
// ----------------------------------------------------------------------------
// cba_map: block used/free map
// One bit per block, one write or read address a cycle, registered read.
// ----------------------------------------------------------------------------
module cba_map
  import cba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  localparam int AW        = $clog2(NUM_BLOCKS)
) (
  input  logic          clk,
  input  map_ctl_t      ctl,
  input  logic [AW-1:0] addr,
  output logic          rd_bit
);

  logic mem [NUM_BLOCKS];

  // Write on request, read every cycle
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= ctl.wr_bit;
    end
    rd_bit <= mem[addr];
  end

endmodule

@@ design/cba_checker.sv @@
// ----------------------------------------------------------------------------
// cba_checker: port-level checks of the block allocator
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module cba_checker
  import cba_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [STAT_W-1:0] status,
  input logic [BLK_W-1:0]  granted_start
);

  // Stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(granted_start))
    else $error("response word changed while stalled");

  // An accepted request drops req_ready in the cycle after it is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another was in progress");

  // Failed requests grant no start block
  a_fail_no_start: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_BUSY || status == ST_PAST) |-> granted_start == '0)
    else $error("start block granted on a failed request");

  // Reset leaves the channels quiet as the map clearing begins
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("channel active straight after reset");

endmodule

bind contiguous_block_allocator_top cba_checker u_cba_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .granted_start (rsp.granted_start)
);

@@ test/contiguous_block_allocator_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contiguous_block_allocator_top_tb: self-checking bench for the allocator
// Drives first-fit allocate, release, claim and undefined-code requests
// through the request channel. A table of directed requests comes first,
// then random traffic built mostly from allocations, releases of live runs
// and in-place growth. Every accepted request is run through a bench block
// map; each response word is checked in order against the predicted or typed grant.
// ----------------------------------------------------------------------------
module contiguous_block_allocator_top_tb;
  import cba_pkg::*;

  localparam int NB          = NUM_BLOCKS_DEF;
  localparam int N_RANDOM    = 1650;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 3000;
  localparam int PAUSE_AT    = 800;
  localparam int DRAIN_WAIT  = 300;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int N_DIRECTED  = 25;

  // Request code that the block does not define
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  start;
  } grant_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [BLK_W-1:0]  range_base;
    logic [BLK_W-1:0]  count;
    bit                fixed;
    grant_t            grant;
  } req_row_t;

  logic clk;
  logic rst;

  cba_req_if req_ch();
  cba_rsp_if rsp_ch();

  contiguous_block_allocator_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Bench copy of the used/free map, 1 means used
  bit       block_used [NB];
  grant_t   grant_q [$];
  req_row_t fixed_q [$];
  int       run_at [$];
  int       run_len [$];
  int       n_req_taken;
  int       n_err;
  int       n_cycle;
  bit       hold_go;

  // Directed requests; grants are typed in only where obvious
  req_row_t directed_tbl [N_DIRECTED] = '{
    '{FUNC_ALLOC,   7'd0,   7'd0,   1'b1, '{ST_OK,   7'd0}},
    '{FUNC_CLAIM,   7'd0,   7'd1,   1'b1, '{ST_BUSY, 7'd0}},
    '{FUNC_NONE,    7'd127, 7'd127, 1'b1, '{ST_BUSY, 7'd0}},
    '{FUNC_ALLOC,   7'd0,   7'd127, 1'b1, '{ST_OK,   7'd1}},
    '{FUNC_ALLOC,   7'd0,   7'd1,   1'b1, '{ST_BUSY, 7'd0}},
    '{FUNC_RELEASE, 7'd0,   7'd127, 1'b1, '{ST_OK,   7'd0}},
    '{FUNC_RELEASE, 7'd127, 7'd127, 1'b1, '{ST_PAST, 7'd0}},
    '{FUNC_CLAIM,   7'd127, 7'd2,   1'b1, '{ST_PAST, 7'd0}},
    '{FUNC_CLAIM,   7'd127, 7'd1,   1'b1, '{ST_OK,   7'd127}},
    '{FUNC_CLAIM,   7'd127, 7'd0,   1'b1, '{ST_OK,   7'd127}},
    '{FUNC_CLAIM,   7'd0,   7'd0,   1'b1, '{ST_OK,   7'd0}},
    '{FUNC_RELEASE, 7'd5,   7'd0,   1'b1, '{ST_OK,   7'd0}},
    '{FUNC_ALLOC,   7'd0,   7'd10,  1'b0, '{ST_OK,   7'd0}},
    '{FUNC_ALLOC,   7'd0,   7'd5,   1'b0, '{ST_OK,   7'd0}},
    '{FUNC_RELEASE, 7'd3,   7'd4,   1'b0, '{ST_OK,   7'd0}},
    '{FUNC_ALLOC,   7'd0,   7'd4,   1'b0, '{ST_OK,   7'd0}},
    '{FUNC_CLAIM,   7'd20,  7'd10,  1'b0, '{ST_OK,   7'd0}},
    '{FUNC_CLAIM,   7'd25,  7'd3,   1'b0, '{ST_OK,   7'd0}},
    '{FUNC_CLAIM,   7'd16,  7'd4,   1'b0, '{ST_OK,   7'd0}},
    '{FUNC_ALLOC,   7'd0,   7'd127, 1'b1, '{ST_BUSY, 7'd0}},
    '{FUNC_RELEASE, 7'd1,   7'd127, 1'b1, '{ST_OK,   7'd0}},
    '{FUNC_ALLOC,   7'd0,   7'd126, 1'b0, '{ST_OK,   7'd0}},
    '{FUNC_CLAIM,   7'd126, 7'd2,   1'b0, '{ST_OK,   7'd0}},
    '{FUNC_NONE,    7'd0,   7'd0,   1'b1, '{ST_BUSY, 7'd0}},
    '{FUNC_RELEASE, 7'd0,   7'd127, 1'b1, '{ST_OK,   7'd0}}
  };

  // Work out the grant of one request and update the bench map
  function automatic grant_t predict_grant(logic [FUNC_W-1:0] func,
                                           logic [BLK_W-1:0] first,
                                           logic [BLK_W-1:0] count);
    grant_t g;
    int     run;
    int     last;
    int     found;
    bit     busy;
    g     = '{ST_OK, '0};
    found = 0;
    busy  = 1'b0;
    last  = int'(first) + int'(count);
    case (func)
      FUNC_ALLOC: begin
        if (count != 0) begin
          run = 0;
          for (int b = 1; b < NB; b++) begin
            if (!block_used[b]) begin
              run++;
              if (run == int'(count)) begin
                found = b + 1 - int'(count);
                break;
              end
            end else begin
              run = 0;
            end
          end
          if (found == 0) begin
            g.status = ST_BUSY;
          end else begin
            for (int k = found; k < found + int'(count); k++) block_used[k] = 1'b1;
            g.start = found[BLK_W-1:0];
          end
        end
      end
      FUNC_RELEASE: begin
        if (last > NB) begin
          g.status = ST_PAST;
          last     = NB;
        end
        // block 0 is reserved and never freed
        for (int k = int'(first); k < last; k++) begin
          if (k != 0) block_used[k] = 1'b0;
        end
      end
      FUNC_CLAIM: begin
        if (count == 0) begin
          g.start = first;
        end else if (last > NB) begin
          g.status = ST_PAST;
        end else begin
          for (int k = int'(first); k < last; k++) busy |= block_used[k];
          if (busy) begin
            g.status = ST_BUSY;
          end else begin
            for (int k = int'(first); k < last; k++) block_used[k] = 1'b1;
            g.start = first;
          end
        end
      end
      default: g.status = ST_BUSY;
    endcase
    return g;
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    n_err++;
    if (n_err <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    n_cycle++;
    if (n_cycle >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Predict on each accepted request, check each accepted response
  always @(posedge clk) begin : watch
    grant_t   g;
    grant_t   want;
    req_row_t row;
    if (req_ch.valid && req_ch.ready) begin
      g   = predict_grant(req_ch.func, req_ch.range_base, req_ch.count);
      row = fixed_q.pop_front();
      grant_q.push_back(row.fixed ? row.grant : g);
      if (g.status == ST_OK && req_ch.count != 0 &&
          (req_ch.func == FUNC_ALLOC || req_ch.func == FUNC_CLAIM)) begin
        run_at.push_back(int'(g.start));
        run_len.push_back(int'(req_ch.count));
      end
      n_req_taken++;
    end
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (grant_q.size() == 0) begin
        note_mismatch("unexpected response, status", -1, int'(rsp_ch.status));
      end else begin
        want = grant_q.pop_front();
        if (rsp_ch.status !== want.status)
          note_mismatch("status", int'(want.status), int'(rsp_ch.status));
        if (rsp_ch.granted_start !== want.start)
          note_mismatch("granted_start", int'(want.start), int'(rsp_ch.granted_start));
      end
    end
  end

  // Response side: stall on a changing pattern, plus one long hold-off
  initial begin : drain
    int rx_cyc;
    int hold_left;
    bit hold_done;
    rx_cyc      = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (rx_cyc[9:8])
          2'd0:    rsp_ch.ready <= 1'b1;
          2'd1:    rsp_ch.ready <= 1'($urandom_range(0, 1));
          2'd2:    rsp_ch.ready <= (rx_cyc[2:0] != 3'd0);
          default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  int burst_left;

  // Offer one word and hold it until it is taken; pace bursts and gaps
  task automatic send_word(req_row_t row);
    int want;
    int gap;
    want = n_req_taken + 1;
    fixed_q.push_back(row);
    req_ch.valid      <= 1'b1;
    req_ch.func       <= row.func;
    req_ch.range_base <= row.range_base;
    req_ch.count      <= row.count;
    do @(negedge clk); while (n_req_taken != want);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  initial begin : stimulus
    req_row_t row;
    int       pick;
    int       idx;
    n_req_taken       = 0;
    n_err             = 0;
    n_cycle           = 0;
    hold_go           = 1'b0;
    burst_left        = 0;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.func       = FUNC_ALLOC;
    req_ch.range_base = '0;
    req_ch.count      = '0;
    block_used        = '{default: 1'b0};
    block_used[0]     = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int i = 0; i < N_DIRECTED; i++) send_word(directed_tbl[i]);

    // Random traffic, checked against the bench map
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == HOLD_AT) hold_go = 1'b1;
      if (n == PAUSE_AT) begin
        // hold the sender until every grant is back
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (grant_q.size() != 0);
      end
      row.fixed      = 1'b0;
      row.grant      = '{ST_OK, '0};
      row.range_base = 7'($urandom_range(0, 127));
      pick           = $urandom_range(0, 99);
      if (pick < 35) begin
        // allocate, mostly small runs
        row.func = FUNC_ALLOC;
        idx      = $urandom_range(0, 99);
        if (idx < 70)      row.count = 7'($urandom_range(1, 8));
        else if (idx < 90) row.count = 7'($urandom_range(9, 40));
        else if (idx < 98) row.count = 7'($urandom_range(41, 127));
        else               row.count = '0;
      end else if (pick < 60 && run_at.size() != 0) begin
        // free a live run, now and then only part of it
        idx            = $urandom_range(0, run_at.size() - 1);
        row.func       = FUNC_RELEASE;
        row.range_base = 7'(run_at[idx]);
        row.count      = 7'(run_len[idx]);
        if ($urandom_range(0, 4) == 0) row.count = 7'($urandom_range(1, run_len[idx]));
        run_at.delete(idx);
        run_len.delete(idx);
      end else if (pick < 70 && run_at.size() != 0) begin
        // grow a live run in place
        idx            = $urandom_range(0, run_at.size() - 1);
        row.func       = FUNC_CLAIM;
        row.range_base = 7'(run_at[idx] + run_len[idx]);
        row.count      = 7'($urandom_range(1, 8));
      end else if (pick < 80) begin
        row.func  = FUNC_CLAIM;
        row.count = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 16));
      end else if (pick < 90) begin
        row.func  = FUNC_RELEASE;
        row.count = 7'($urandom_range(0, 127));
      end else if (pick < 95) begin
        row.func  = FUNC_NONE;
        row.count = 7'($urandom_range(0, 127));
      end else begin
        // ranges that end next to, at or past the last block
        row.func       = ($urandom_range(0, 1) == 0) ? FUNC_CLAIM : FUNC_RELEASE;
        row.range_base = 7'($urandom_range(100, 127));
        row.count      = 7'($urandom_range(NB - int'(row.range_base) - 1, 127));
      end
      send_word(row);
    end

    // Drop valid, drain the outstanding grants, then let the block settle
    req_ch.valid <= 1'b0;
    while (grant_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (n_err == 0 && grant_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/cba_pkg.sv
design/cba_if.sv
design/cba_map.sv
design/contiguous_block_allocator_top.sv
design/cba_checker.sv
test/contiguous_block_allocator_top_tb.sv
